@@ hdl/wpspin_pkg.sv @@
// Shared constants, the pipeline payload type and digit helpers for the WPS PIN block.
package wpspin_pkg;

  localparam int MAC_W      = 24;
  localparam int BODY_DIGITS = 7;
  localparam int BCD_BODY_W = 4 * BODY_DIGITS;
  localparam int PIN_W      = 27;
  localparam int PIN_BCD_W  = 32;
  localparam int DIGIT_W    = 4;
  localparam int SUM_W      = 8;
  localparam int DD_STEPS   = 8;

  localparam logic [MAC_W-1:0]   PIN_MODULUS = 24'd10000000;
  localparam logic [DIGIT_W-1:0] DIGIT_BASE  = 4'd10;

  typedef struct packed {
    logic [BCD_BODY_W-1:0] bcd;
    logic [MAC_W-1:0]      bin;
    logic [MAC_W-1:0]      body;
  } dd_t;

  // Remainder of a small sum by ten, by reciprocal multiplication.
  function automatic logic [DIGIT_W-1:0] mod10(input logic [SUM_W-1:0] s);
    logic [15:0]      prod;
    logic [DIGIT_W:0] q;
    logic [SUM_W-1:0] q10;
    logic [SUM_W-1:0] rem;
    prod = {8'd0, s} * 16'd205;
    q    = prod[15:11];
    q10  = {q, 3'b000} + {2'b00, q, 1'b0};
    rem  = s - q10;
    return rem[DIGIT_W-1:0];
  endfunction

  function automatic logic bcd_ok(input logic [PIN_BCD_W-1:0] v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < PIN_BCD_W / 4; i++) begin
      if (v[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

@@ hdl/wpspin_reduce.sv @@
// First pipeline stage: reduces the MAC value modulo ten million.
module wpspin_reduce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [wpspin_pkg::MAC_W-1:0] in_mac,
  output logic                       out_valid,
  output wpspin_pkg::dd_t            out_data
);
  import wpspin_pkg::*;

  logic            valid_r;
  dd_t             data_r;
  dd_t             data_nxt;
  logic [MAC_W-1:0] body;

  always_comb begin
    body = (in_mac >= PIN_MODULUS) ? in_mac - PIN_MODULUS : in_mac;
    data_nxt.bcd  = '0;
    data_nxt.bin  = body;
    data_nxt.body = body;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ hdl/wpspin_dabble.sv @@
// One binary to BCD conversion stage that shifts in eight bits of the body.
module wpspin_dabble (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  wpspin_pkg::dd_t in_data,
  output logic            out_valid,
  output wpspin_pkg::dd_t out_data
);
  import wpspin_pkg::*;

  logic valid_r;
  dd_t  data_r;
  dd_t  data_nxt;

  always_comb begin
    logic [BCD_BODY_W-1:0] bcd;
    logic [MAC_W-1:0]      bin;
    bcd = in_data.bcd;
    bin = in_data.bin;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int d = 0; d < BODY_DIGITS; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BCD_BODY_W-2:0], bin[MAC_W-1]};
      bin = {bin[MAC_W-2:0], 1'b0};
    end
    data_nxt.bcd  = bcd;
    data_nxt.bin  = bin;
    data_nxt.body = in_data.body;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ hdl/wpspin_check.sv @@
// Weighted digit sum, check digit and the registered result of the PIN pipeline.
module wpspin_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  wpspin_pkg::dd_t                   in_data,
  output logic                              out_valid,
  output logic [wpspin_pkg::PIN_W-1:0]      out_pin_value,
  output logic [wpspin_pkg::PIN_BCD_W-1:0]  out_pin_bcd,
  output logic [wpspin_pkg::DIGIT_W-1:0]    out_check_digit
);
  import wpspin_pkg::*;

  logic                  sa_valid_r;
  logic [SUM_W-1:0]      sa_sum_r;
  logic [SUM_W-1:0]      sa_sum_nxt;
  logic [PIN_W-1:0]      sa_x10_r;
  logic [PIN_W-1:0]      sa_x10_nxt;
  logic [BCD_BODY_W-1:0] sa_bcd_r;

  logic                  valid_r;
  logic [PIN_W-1:0]      value_r;
  logic [PIN_BCD_W-1:0]  bcd_r;
  logic [DIGIT_W-1:0]    check_r;
  logic [DIGIT_W-1:0]    check_nxt;
  logic [DIGIT_W-1:0]    rem;

  always_comb begin
    logic [5:0] odd;
    logic [4:0] even;
    odd  = 6'({2'b00, in_data.bcd[3:0]}) + 6'({2'b00, in_data.bcd[11:8]})
         + 6'({2'b00, in_data.bcd[19:16]}) + 6'({2'b00, in_data.bcd[27:24]});
    even = 5'({1'b0, in_data.bcd[7:4]}) + 5'({1'b0, in_data.bcd[15:12]})
         + 5'({1'b0, in_data.bcd[23:20]});
    sa_sum_nxt = {1'b0, odd, 1'b0} + {2'b00, odd} + {3'b000, even};
    sa_x10_nxt = {in_data.body, 3'b000} + {2'b00, in_data.body, 1'b0};
  end

  always_comb begin
    rem       = mod10(sa_sum_r);
    check_nxt = (rem == '0) ? '0 : DIGIT_BASE - rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      sa_valid_r <= in_valid;
      valid_r    <= sa_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_sum_r <= sa_sum_nxt;
    sa_x10_r <= sa_x10_nxt;
    sa_bcd_r <= in_data.bcd;
    value_r  <= sa_x10_r + {{(PIN_W-DIGIT_W){1'b0}}, check_nxt};
    bcd_r    <= {sa_bcd_r, check_nxt};
    check_r  <= check_nxt;
  end

  assign out_valid       = valid_r;
  assign out_pin_value   = value_r;
  assign out_pin_bcd     = bcd_r;
  assign out_check_digit = check_r;

  a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (check_r <= 4'd9))
    else $error("check digit out of range");

  a_check_in_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (bcd_r[DIGIT_W-1:0] == check_r))
    else $error("check digit differs from last BCD digit");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> bcd_ok(bcd_r))
    else $error("BCD result holds a digit above nine");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (value_r <= 27'd99999999))
    else $error("PIN value out of range");

endmodule

@@ hdl/wps_pin_from_mac.sv @@
// WPS PIN generator: pipelined top level from low MAC bytes to eight-digit PIN.
//
// Input channel: drive in_mac_low and raise start; the transfer is taken at
// the rising edge where start is high and busy is low. Busy is always low, so
// a new transfer may be made in every cycle.
// Result channel: out_valid is high for exactly one cycle with out_pin_value,
// out_pin_bcd and out_check_digit; the result is taken at the end of it.
// The path from the accepting edge to the result runs through six register
// stages: the modulo reduction, three binary to BCD stages of eight bits each,
// the weighted digit sum, and the check digit with the output register.
// Throughput is one item per cycle, since every stage takes a new item in
// each cycle.
// Results leave in the order in which inputs were taken.
// Reset, synchronous and active low, clears every valid bit, so items in
// flight are dropped and nothing is shown until new input arrives.
// The receiver has no way to stall the block; results must be taken when
// shown.
module wps_pin_from_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [wpspin_pkg::MAC_W-1:0]      in_mac_low,
  output logic                              out_valid,
  output logic [wpspin_pkg::PIN_W-1:0]      out_pin_value,
  output logic [wpspin_pkg::PIN_BCD_W-1:0]  out_pin_bcd,
  output logic [wpspin_pkg::DIGIT_W-1:0]    out_check_digit
);
  import wpspin_pkg::*;

  logic accept;
  logic v0;
  logic v1;
  logic v2;
  logic v3;
  dd_t  d0;
  dd_t  d1;
  dd_t  d2;
  dd_t  d3;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  wpspin_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_mac    (in_mac_low),
    .out_valid (v0),
    .out_data  (d0)
  );

  wpspin_dabble u_dabble0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0),
    .in_data   (d0),
    .out_valid (v1),
    .out_data  (d1)
  );

  wpspin_dabble u_dabble1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1),
    .in_data   (d1),
    .out_valid (v2),
    .out_data  (d2)
  );

  wpspin_dabble u_dabble2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2),
    .in_data   (d2),
    .out_valid (v3),
    .out_data  (d3)
  );

  wpspin_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (v3),
    .in_data         (d3),
    .out_valid       (out_valid),
    .out_pin_value   (out_pin_value),
    .out_pin_bcd     (out_pin_bcd),
    .out_check_digit (out_check_digit)
  );

  a_reduced_body: assert property (@(posedge clk) disable iff (!rst_n)
    v0 |-> (d0.body < PIN_MODULUS))
    else $error("reduced body not below ten million");

  a_bcd_drained: assert property (@(posedge clk) disable iff (!rst_n)
    v3 |-> (d3.bin == '0))
    else $error("binary bits left after BCD conversion");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_valid)
    else $error("result missing six cycles after a transfer");

endmodule
